// ----- hdl/cartesian_to_polar_assert.svh -----
// Assertion macros for the cartesian_to_polar block.
// Included by the top level; needs no package.
`ifndef CARTESIAN_TO_POLAR_ASSERT_SVH
`define CARTESIAN_TO_POLAR_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset
`define CPOL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked outside reset
`define CPOL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CPOL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CPOL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- hdl/cpol_pkg.sv -----
// Shared constants, types and tables for the cartesian_to_polar CORDIC pipeline.
// No dependencies.
`default_nettype none
package cpol_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int GUARD      = 16;
	localparam int ITERATIONS = 16;
	localparam int MAX_ITER   = 32;
	localparam int ITER_CNT   = (ITERATIONS < MAX_ITER) ? ITERATIONS : MAX_ITER;

	// datapath: sign, one bit for the negated minimum, guard bits, growth headroom
	localparam int XW        = DATA_WIDTH + 1 + GUARD + 3;
	localparam int ZW        = 32;
	localparam int IDX_W     = 5;
	localparam int KW        = 32;
	localparam int PW        = (XW - 1) + KW;
	localparam int MAG_SHIFT = 31 + GUARD;

	localparam logic [DATA_WIDTH-1:0] MAG_MAX = DATA_WIDTH'(46341);

	// round(atan(2^-i) * 2^31 / pi)
	localparam logic [ZW-1:0] ATAN_TAB [MAX_ITER] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	// squared inverse gain in Q62: shrink by floor(q / (4^i + 1)) for each rotation
	localparam logic [63:0] GQ_0  = 64'd1 << 62;
	localparam logic [63:0] GQ_1  = (ITER_CNT > 0) ? GQ_0 - GQ_0 / ((64'd1 << 0) + 64'd1) : GQ_0;
	localparam logic [63:0] GQ_2  = (ITER_CNT > 1) ? GQ_1 - GQ_1 / ((64'd1 << 2) + 64'd1) : GQ_1;
	localparam logic [63:0] GQ_3  = (ITER_CNT > 2) ? GQ_2 - GQ_2 / ((64'd1 << 4) + 64'd1) : GQ_2;
	localparam logic [63:0] GQ_4  = (ITER_CNT > 3) ? GQ_3 - GQ_3 / ((64'd1 << 6) + 64'd1) : GQ_3;
	localparam logic [63:0] GQ_5  = (ITER_CNT > 4) ? GQ_4 - GQ_4 / ((64'd1 << 8) + 64'd1) : GQ_4;
	localparam logic [63:0] GQ_6  = (ITER_CNT > 5) ? GQ_5 - GQ_5 / ((64'd1 << 10) + 64'd1) : GQ_5;
	localparam logic [63:0] GQ_7  = (ITER_CNT > 6) ? GQ_6 - GQ_6 / ((64'd1 << 12) + 64'd1) : GQ_6;
	localparam logic [63:0] GQ_8  = (ITER_CNT > 7) ? GQ_7 - GQ_7 / ((64'd1 << 14) + 64'd1) : GQ_7;
	localparam logic [63:0] GQ_9  = (ITER_CNT > 8) ? GQ_8 - GQ_8 / ((64'd1 << 16) + 64'd1) : GQ_8;
	localparam logic [63:0] GQ_10 = (ITER_CNT > 9) ? GQ_9 - GQ_9 / ((64'd1 << 18) + 64'd1) : GQ_9;
	localparam logic [63:0] GQ_11 = (ITER_CNT > 10) ? GQ_10 - GQ_10 / ((64'd1 << 20) + 64'd1) : GQ_10;
	localparam logic [63:0] GQ_12 = (ITER_CNT > 11) ? GQ_11 - GQ_11 / ((64'd1 << 22) + 64'd1) : GQ_11;
	localparam logic [63:0] GQ_13 = (ITER_CNT > 12) ? GQ_12 - GQ_12 / ((64'd1 << 24) + 64'd1) : GQ_12;
	localparam logic [63:0] GQ_14 = (ITER_CNT > 13) ? GQ_13 - GQ_13 / ((64'd1 << 26) + 64'd1) : GQ_13;
	localparam logic [63:0] GQ_15 = (ITER_CNT > 14) ? GQ_14 - GQ_14 / ((64'd1 << 28) + 64'd1) : GQ_14;
	localparam logic [63:0] GQ_16 = (ITER_CNT > 15) ? GQ_15 - GQ_15 / ((64'd1 << 30) + 64'd1) : GQ_15;
	localparam logic [63:0] GQ_17 = (ITER_CNT > 16) ? GQ_16 - GQ_16 / ((64'd1 << 32) + 64'd1) : GQ_16;
	localparam logic [63:0] GQ_18 = (ITER_CNT > 17) ? GQ_17 - GQ_17 / ((64'd1 << 34) + 64'd1) : GQ_17;
	localparam logic [63:0] GQ_19 = (ITER_CNT > 18) ? GQ_18 - GQ_18 / ((64'd1 << 36) + 64'd1) : GQ_18;
	localparam logic [63:0] GQ_20 = (ITER_CNT > 19) ? GQ_19 - GQ_19 / ((64'd1 << 38) + 64'd1) : GQ_19;
	localparam logic [63:0] GQ_21 = (ITER_CNT > 20) ? GQ_20 - GQ_20 / ((64'd1 << 40) + 64'd1) : GQ_20;
	localparam logic [63:0] GQ_22 = (ITER_CNT > 21) ? GQ_21 - GQ_21 / ((64'd1 << 42) + 64'd1) : GQ_21;
	localparam logic [63:0] GQ_23 = (ITER_CNT > 22) ? GQ_22 - GQ_22 / ((64'd1 << 44) + 64'd1) : GQ_22;
	localparam logic [63:0] GQ_24 = (ITER_CNT > 23) ? GQ_23 - GQ_23 / ((64'd1 << 46) + 64'd1) : GQ_23;
	localparam logic [63:0] GQ_25 = (ITER_CNT > 24) ? GQ_24 - GQ_24 / ((64'd1 << 48) + 64'd1) : GQ_24;
	localparam logic [63:0] GQ_26 = (ITER_CNT > 25) ? GQ_25 - GQ_25 / ((64'd1 << 50) + 64'd1) : GQ_25;
	localparam logic [63:0] GQ_27 = (ITER_CNT > 26) ? GQ_26 - GQ_26 / ((64'd1 << 52) + 64'd1) : GQ_26;
	localparam logic [63:0] GQ_28 = (ITER_CNT > 27) ? GQ_27 - GQ_27 / ((64'd1 << 54) + 64'd1) : GQ_27;
	localparam logic [63:0] GQ_29 = (ITER_CNT > 28) ? GQ_28 - GQ_28 / ((64'd1 << 56) + 64'd1) : GQ_28;
	localparam logic [63:0] GQ_30 = (ITER_CNT > 29) ? GQ_29 - GQ_29 / ((64'd1 << 58) + 64'd1) : GQ_29;
	localparam logic [63:0] GQ_31 = (ITER_CNT > 30) ? GQ_30 - GQ_30 / ((64'd1 << 60) + 64'd1) : GQ_30;
	localparam logic [63:0] GQ_32 = (ITER_CNT > 31) ? GQ_31 - GQ_31 / ((64'd1 << 62) + 64'd1) : GQ_31;

	// CORDIC gain compensation in Q31: integer square root, evaluated at elaboration
	function automatic logic [63:0] gain_k_f();
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] bit_v;
		n = GQ_32;
		res = '0;
		bit_v = 64'd1 << 62;
		while (bit_v > n) begin
			bit_v = bit_v >> 2;
		end
		while (bit_v != 64'd0) begin
			if (n >= res + bit_v) begin
				n = n - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	localparam logic [KW-1:0] GAIN_K = KW'(gain_k_f());

	typedef struct packed {
		logic                 valid;
		logic                 zero;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic [ZW-1:0]        z;
	} cpol_vec_t;

endpackage
`default_nettype wire

// ----- hdl/cartesian_to_polar.sv -----
// Top level of the cartesian-to-polar converter: prerotation, CORDIC chain, gain stage.
// Depends on cpol_pkg, cpol_prerot, cpol_micro_rot, cpol_gain and the assertion header.
//
// Usage:
//   Drive x_component and y_component with start high for one cycle per transaction.
//   busy is always low: a transaction is taken at every edge where start is high.
//   Throughput is one transaction per clock cycle, without gaps.
//   done pulses for one cycle with magnitude and angle valid once a transaction
//   has passed through the pipeline: one prerotation stage, one stage per
//   CORDIC microrotation (16), one gain multiply stage and one rounding stage.
//   Results come out in acceptance order.
//   magnitude is round(|v|) after gain compensation, saturated to all ones.
//   angle is a binary angle where 2^15 is pi; +pi wraps to the -pi code.
//   A zero vector yields magnitude 0 and angle 0.
//   The receiver cannot stall: every result is shown exactly once.
//   arst_n low clears every valid bit; transactions in flight are dropped.
`default_nettype none
`include "cartesian_to_polar_assert.svh"
module cartesian_to_polar
	import cpol_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic signed [DATA_WIDTH-1:0] x_component,
	input  wire logic signed [DATA_WIDTH-1:0] y_component,
	output logic                              done,
	output logic [DATA_WIDTH-1:0]             magnitude,
	output logic signed [DATA_WIDTH-1:0]      angle
);

	cpol_vec_t chain [ITER_CNT+1];
	logic      take;

	// every stage advances each cycle, so nothing ever holds the input off
	assign busy = 1'b0;
	assign take = start && !busy;

	cpol_prerot u_prerot (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.x_in   (x_component),
		.y_in   (y_component),
		.vec    (chain[0])
	);

	for (genvar i = 0; i < ITER_CNT; i++) begin : g_rot
		cpol_micro_rot u_rot (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (IDX_W'(i)),
			.atan    (ATAN_TAB[i]),
			.vec_in  (chain[i]),
			.vec_out (chain[i+1])
		);
	end

	cpol_gain u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.vec_in    (chain[ITER_CNT]),
		.done      (done),
		.magnitude (magnitude),
		.angle     (angle)
	);

	`CPOL_ASSERT_IMP(a_latency, clk, arst_n, take, ##(ITER_CNT+3) done, "result strobe missing after fixed latency")
	`CPOL_ASSERT_IMP(a_no_phantom, clk, arst_n, done, $past(take, ITER_CNT+3), "result without a matching transaction")
	`CPOL_ASSERT_IMP(a_zero_vec, clk, arst_n, take && x_component == '0 && y_component == '0, ##(ITER_CNT+3) (magnitude == '0 && angle == '0), "zero vector did not give zero result")
	`CPOL_ASSERT_NXT(a_mag_bound, clk, arst_n, 1'b1, !done || magnitude <= MAG_MAX, "magnitude above the largest reachable length")

endmodule
`default_nettype wire

// ----- hdl/cpol_prerot.sv -----
// Input stage: registers a transaction, folds the left half-plane onto the right.
// Depends on cpol_pkg.
`default_nettype none
module cpol_prerot
	import cpol_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         take,
	input  wire logic signed [DATA_WIDTH-1:0] x_in,
	input  wire logic signed [DATA_WIDTH-1:0] y_in,
	output cpol_vec_t                         vec
);

	logic signed [DATA_WIDTH:0] xe;
	logic signed [DATA_WIDTH:0] ye;
	logic [ZW-1:0]              z0;
	cpol_vec_t                  vec_s1;

	always_comb begin
		xe = {x_in[DATA_WIDTH-1], x_in};
		ye = {y_in[DATA_WIDTH-1], y_in};
		z0 = '0;
		// rotate by pi
		if (x_in[DATA_WIDTH-1]) begin
			xe = -xe;
			ye = -ye;
			z0 = ZW'(1) << (ZW - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_s1 <= '0;
		end else begin
			vec_s1.valid <= take;
			vec_s1.zero  <= (x_in == '0) && (y_in == '0);
			vec_s1.x     <= {{(XW-DATA_WIDTH-1-GUARD){xe[DATA_WIDTH]}}, xe, GUARD'(0)};
			vec_s1.y     <= {{(XW-DATA_WIDTH-1-GUARD){ye[DATA_WIDTH]}}, ye, GUARD'(0)};
			vec_s1.z     <= z0;
		end
	end

	assign vec = vec_s1;

endmodule
`default_nettype wire

// ----- hdl/cpol_micro_rot.sv -----
// One CORDIC vectoring microrotation with its pipeline register.
// Depends on cpol_pkg.
`default_nettype none
module cpol_micro_rot
	import cpol_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IDX_W-1:0] idx,
	input  wire logic [ZW-1:0]    atan,
	input  wire cpol_vec_t        vec_in,
	output cpol_vec_t             vec_out
);

	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	cpol_vec_t            vec_s1;

	assign xs = vec_in.x >>> idx;
	assign ys = vec_in.y >>> idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_s1 <= '0;
		end else begin
			vec_s1.valid <= vec_in.valid;
			vec_s1.zero  <= vec_in.zero;
			// drive y toward zero
			if (!vec_in.y[XW-1]) begin
				vec_s1.x <= vec_in.x + ys;
				vec_s1.y <= vec_in.y - xs;
				vec_s1.z <= vec_in.z + atan;
			end else begin
				vec_s1.x <= vec_in.x - ys;
				vec_s1.y <= vec_in.y + xs;
				vec_s1.z <= vec_in.z - atan;
			end
		end
	end

	assign vec_out = vec_s1;

endmodule
`default_nettype wire

// ----- hdl/cpol_gain.sv -----
// Output stages: gain compensation multiply, rounding, saturation, angle rounding.
// Depends on cpol_pkg.
`default_nettype none
module cpol_gain
	import cpol_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cpol_vec_t              vec_in,
	output logic                        done,
	output logic [DATA_WIDTH-1:0]       magnitude,
	output logic signed [DATA_WIDTH-1:0] angle
);

	localparam logic [ZW-1:0] ANG_HALF = ZW'(1) << (ZW - 1 - DATA_WIDTH);
	localparam logic [PW-1:0] MAG_HALF = PW'(1) << (MAG_SHIFT - 1);

	logic [XW-2:0]         xmag;
	logic [ZW-1:0]         zr;
	logic [PW-1:0]         rnd;

	logic                  valid_s1;
	logic                  zero_s1;
	logic [PW-1:0]         prod_s1;
	logic [DATA_WIDTH-1:0] ang_s1;

	logic                  valid_s2;
	logic [DATA_WIDTH-1:0] mag_s2;
	logic [DATA_WIDTH-1:0] ang_s2;

	// clamp a negative final x to zero
	assign xmag = vec_in.x[XW-1] ? '0 : vec_in.x[XW-2:0];
	assign zr   = vec_in.z + ANG_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			zero_s1  <= 1'b0;
			prod_s1  <= '0;
			ang_s1   <= '0;
		end else begin
			valid_s1 <= vec_in.valid;
			zero_s1  <= vec_in.zero;
			prod_s1  <= PW'(xmag) * PW'(GAIN_K);
			ang_s1   <= vec_in.zero ? '0 : zr[ZW-1 -: DATA_WIDTH];
		end
	end

	assign rnd = prod_s1 + MAG_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			mag_s2   <= '0;
			ang_s2   <= '0;
		end else begin
			valid_s2 <= valid_s1;
			ang_s2   <= ang_s1;
			if (zero_s1) begin
				mag_s2 <= '0;
			end else if (|rnd[PW-1:MAG_SHIFT+DATA_WIDTH]) begin
				mag_s2 <= '1;
			end else begin
				mag_s2 <= rnd[MAG_SHIFT +: DATA_WIDTH];
			end
		end
	end

	assign done      = valid_s2;
	assign magnitude = mag_s2;
	assign angle     = ang_s2;

endmodule
`default_nettype wire

// ----- sim/cartesian_to_polar_checker.sv -----
// Checker for cartesian_to_polar: predicts magnitude and angle for every accepted vector
// and compares them in order against the done strobes. Depends on cpol_pkg.
module cartesian_to_polar_checker
	import cpol_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic signed [DATA_WIDTH-1:0] x_component,
	input  logic signed [DATA_WIDTH-1:0] y_component,
	input  logic                         done,
	input  logic [DATA_WIDTH-1:0]        magnitude,
	input  logic signed [DATA_WIDTH-1:0] angle,
	output int                           mismatches,
	output int                           outstanding,
	output int                           compared
);

	localparam int FRAC_BITS  = 16;
	localparam int STEP_LIMIT = 32;
	localparam int STEPS      = (ITERATIONS < STEP_LIMIT) ? ITERATIONS : STEP_LIMIT;
	localparam int REPORT_MAX = 10;

	// atan(2^-i) in units where 2^32 is a full turn
	localparam logic [31:0] ROT_ANGLE [STEP_LIMIT] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef struct {
		logic signed [DATA_WIDTH-1:0] x;
		logic signed [DATA_WIDTH-1:0] y;
		logic [DATA_WIDTH-1:0]        magnitude;
		logic signed [DATA_WIDTH-1:0] angle;
	} polar_t;

	// Q31 inverse of the CORDIC growth over STEPS rotations
	function automatic logic [63:0] shrink_factor();
		logic [63:0] q;
		logic [63:0] root;
		logic [63:0] trial;
		q = 64'd1 << 62;
		for (int i = 0; i < STEPS; i++) begin
			q = q - q / ((64'd1 << (2 * i)) + 64'd1);
		end
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= q)
				root = trial;
		end
		return root;
	endfunction

	localparam logic [63:0] SHRINK = shrink_factor();

	function automatic polar_t to_polar(logic signed [DATA_WIDTH-1:0] xi,
			logic signed [DATA_WIDTH-1:0] yi);
		polar_t       r;
		longint       x;
		longint       y;
		longint       z;
		longint       xs;
		longint       ys;
		logic [63:0]  xu;
		logic [127:0] prod;
		logic [31:0]  turn;
		r.x = xi;
		r.y = yi;
		r.magnitude = '0;
		r.angle = '0;
		if (xi == 0 && yi == 0)
			return r;
		x = longint'(xi);
		y = longint'(yi);
		z = 0;
		// fold the left half plane over by pi
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 64'sd1 <<< 31;
		end
		x = x <<< FRAC_BITS;
		y = y <<< FRAC_BITS;
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + longint'(ROT_ANGLE[i]);
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - longint'(ROT_ANGLE[i]);
			end
		end
		if (x < 0)
			x = 0;
		xu = x;
		prod = xu * SHRINK + (128'd1 << (30 + FRAC_BITS));
		prod = prod >> (31 + FRAC_BITS);
		if (prod > {{(128 - DATA_WIDTH){1'b0}}, {DATA_WIDTH{1'b1}}})
			r.magnitude = '1;
		else
			r.magnitude = prod[DATA_WIDTH-1:0];
		turn = z[31:0];
		if (DATA_WIDTH < 32)
			turn = (turn + (32'd1 << (31 - DATA_WIDTH))) >> (32 - DATA_WIDTH);
		r.angle = turn[DATA_WIDTH-1:0];
		return r;
	endfunction

	polar_t polar_due [$];
	int     n_bad = 0;
	int     n_cmp = 0;

	always @(posedge clk) begin
		polar_t want;
		if (arst_n) begin
			if (start && !busy)
				polar_due.push_back(to_polar(x_component, y_component));
			if (done) begin
				n_cmp++;
				if (polar_due.size() == 0) begin
					n_bad++;
					if (n_bad <= REPORT_MAX)
						$display("unexpected result: magnitude=%0d angle=%0d", magnitude, angle);
				end else begin
					want = polar_due.pop_front();
					if (magnitude !== want.magnitude || angle !== want.angle) begin
						n_bad++;
						if (n_bad <= REPORT_MAX)
							$display("mismatch x=%0d y=%0d: magnitude exp %0d got %0d, angle exp %0d got %0d",
								want.x, want.y, want.magnitude, magnitude, want.angle, angle);
					end
				end
			end
		end
		mismatches <= n_bad;
		compared <= n_cmp;
		outstanding <= polar_due.size();
	end

endmodule

// ----- sim/tb_cartesian_to_polar.sv -----
// Testbench top for cartesian_to_polar: drives directed and random vectors with random gaps
// and reports the verdict. Depends on cpol_pkg, the block and cartesian_to_polar_checker.
module tb_cartesian_to_polar;
	import cpol_pkg::*;

	localparam int RANDOM_VECTORS = 1400;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int FLUSH_CYCLES   = 24;
	localparam int DIRECTED       = 22;
	localparam int MAX_GAP        = 11;

	localparam int DIR_X [DIRECTED] = '{
		0, 32767, -32768, 0, 0, 32767, -32768, -32768, 32767, -1, 1,
		0, 0, -1, -1, 1, -32768, -32768, 3, -3, 30000, -30000
	};
	localparam int DIR_Y [DIRECTED] = '{
		0, 0, 0, 32767, -32768, 32767, -32768, 32767, -32768, 0, 0,
		1, -1, -1, 1, -1, -1, 1, 4, -4, -1, 0
	};

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic signed [DATA_WIDTH-1:0] x_component = '0;
	logic signed [DATA_WIDTH-1:0] y_component = '0;
	logic                         busy;
	logic                         done;
	logic [DATA_WIDTH-1:0]        magnitude;
	logic signed [DATA_WIDTH-1:0] angle;

	int mismatches;
	int outstanding;
	int compared;
	int sent = 0;
	int cycles = 0;
	bit steady = 1'b0;

	always #4 clk = ~clk;

	cartesian_to_polar uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.x_component(x_component),
		.y_component(y_component),
		.done       (done),
		.magnitude  (magnitude),
		.angle      (angle)
	);

	cartesian_to_polar_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.x_component(x_component),
		.y_component(y_component),
		.done       (done),
		.magnitude  (magnitude),
		.angle      (angle),
		.mismatches (mismatches),
		.outstanding(outstanding),
		.compared   (compared)
	);

	// hold start low through the gap, then present one transaction until it is taken
	task automatic send_vector(input logic signed [DATA_WIDTH-1:0] xv,
			input logic signed [DATA_WIDTH-1:0] yv);
		int gap;
		gap = steady ? 0 : $urandom_range(MAX_GAP, 0);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		x_component <= xv;
		y_component <= yv;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	// drop start and wait for every predicted result to come back
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic logic signed [DATA_WIDTH-1:0] pick_component(int shape);
		logic signed [DATA_WIDTH-1:0] v;
		case (shape)
			0: v = DATA_WIDTH'($urandom);
			1: v = DATA_WIDTH'($urandom_range(32, 0) - 16);
			default: begin
				case ($urandom_range(4, 0))
					0: v = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
					1: v = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
					2: v = '0;
					3: v = '1;
					default: v = DATA_WIDTH'(1);
				endcase
			end
		endcase
		return v;
	endfunction

	initial begin
		int sel;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED; i++)
			send_vector(DATA_WIDTH'(DIR_X[i]), DATA_WIDTH'(DIR_Y[i]));
		drain();

		for (int i = 0; i < RANDOM_VECTORS; i++) begin
			if (i % 100 == 0)
				steady = ($urandom_range(3, 0) == 0);
			if (i == RANDOM_VECTORS / 2)
				drain();
			sel = $urandom_range(99, 0);
			if (sel < 65)
				send_vector(pick_component(0), pick_component(0));
			else if (sel < 80)
				send_vector(pick_component(1), pick_component(1));
			else if (sel < 90)
				send_vector(pick_component(2), pick_component(0));
			else if (sel < 95)
				send_vector(pick_component(0), pick_component(2));
			else
				send_vector(pick_component(2), pick_component(2));
		end
		drain();
		repeat (FLUSH_CYCLES) @(posedge clk);

		$display("Sent %0d vectors (%0d directed edge cases, rest random with gaps and bursts),",
			sent, DIRECTED);
		$display("compared %0d results on magnitude and angle, %0d mismatching.",
			compared, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("tb_cartesian_to_polar: PASS");
		else
			$display("tb_cartesian_to_polar: FAIL");
		$finish;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("tb_cartesian_to_polar: FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/cpol_pkg.sv
hdl/cpol_prerot.sv
hdl/cpol_micro_rot.sv
hdl/cpol_gain.sv
hdl/cartesian_to_polar.sv
sim/cartesian_to_polar_checker.sv
sim/tb_cartesian_to_polar.sv
